@@ src/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ src/bfa_pkg.sv @@
// Package with the status codes, commands and controller interface types of the allocator.
package bfa_pkg;
	// Size of the managed region in units; addresses are 11 bits wide.
	localparam int REGION_UNITS = 2048;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_FIT     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL = 2'd3;
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Datapath operation selected by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_SCAN_FREE,
		OP_SCAN_USED,
		OP_FREE_POS,
		OP_SHIFT_FREE_DOWN,
		OP_SHIFT_FREE_UP,
		OP_SHIFT_USED_DOWN,
		OP_COMMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   first;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic found;
		logic exact_fit;
		logic join_prev;
		logic join_next;
		logic free_full;
		logic used_full;
	} dp_stat_t;
endpackage

@@ src/bfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bfa_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Registered read; a read of the entry being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/bfa_datapath.sv @@
// Datapath of the allocator: free and used tables, scan registers and merge arithmetic.
module bfa_datapath #(
	parameter int FREE_ENTRIES = 64,
	parameter int USED_ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bfa_pkg::dp_cmd_t cmd,
	output bfa_pkg::dp_stat_t stat,
	input  logic             in_command,
	input  logic [11:0]      in_size,
	input  logic [10:0]      in_addr,
	output logic [10:0]      res_addr,
	output logic             req_is_free,
	output logic             size_zero
);
	localparam int LW = $clog2(bfa_pkg::REGION_UNITS + 1);
	localparam int FA = $clog2(FREE_ENTRIES);
	localparam int UA = $clog2(USED_ENTRIES);
	localparam int FC = $clog2(FREE_ENTRIES + 1);
	localparam int UC = $clog2(USED_ENTRIES + 1);
	localparam int IW = ((FC > UC) ? FC : UC) + 1;

	// Request registers.
	logic          cmd_q;
	logic [LW-1:0] size_q;
	logic [LW-1:0] addr_q;
	// Counts.
	logic [FC-1:0] free_count_q;
	logic [UC-1:0] used_count_q;
	// Scan state: issue index; the read data and its index follow in the next cycle.
	logic [IW-1:0] idx_q;
	logic          rvalid_q;
	logic [IW-1:0] ridx_q;
	logic          found_q;
	logic [FC-1:0] best_q;
	logic [LW-1:0] best_len_q;
	logic [LW-1:0] best_start_q;
	logic [UC-1:0] uhit_q;
	logic [LW-1:0] ulen_q;
	// Neighbour data for a free.
	logic [FC-1:0] pos_q;
	logic [LW-1:0] prev_start_q, prev_len_q, next_start_q, next_len_q;
	logic          pos_done_q;

	// Memory ports.
	logic          fwe, uwe;
	logic [FA-1:0] fwaddr, fraddr;
	logic [UA-1:0] uwaddr, uraddr;
	logic [2*LW-1:0] fwdata, frdata, uwdata, urdata;
	logic [LW-1:0] f_start, f_len, u_start, u_len;

	bfa_ram #(.WIDTH(2*LW), .DEPTH(FREE_ENTRIES)) u_free_ram (
		.clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata),
		.raddr(fraddr), .rdata(frdata));
	bfa_ram #(.WIDTH(2*LW), .DEPTH(USED_ENTRIES)) u_used_ram (
		.clk(clk), .we(uwe), .waddr(uwaddr), .wdata(uwdata),
		.raddr(uraddr), .rdata(urdata));

	assign f_start = frdata[2*LW-1:LW];
	assign f_len   = frdata[LW-1:0];
	assign u_start = urdata[2*LW-1:LW];
	assign u_len   = urdata[LW-1:0];

	// Entry 0 of the free table reads as the reset segment until first written.
	logic entry0_valid_q;
	logic [LW-1:0] f_start_v, f_len_v;
	always_comb begin
		f_start_v = f_start;
		f_len_v   = f_len;
		if (!entry0_valid_q && ridx_q == '0) begin
			f_start_v = '0;
			f_len_v   = LW'(bfa_pkg::REGION_UNITS);
		end
	end

	// Derived flags.
	logic [LW:0] prev_end, req_end;
	logic        jp, jn;
	assign prev_end = {1'b0, prev_start_q} + {1'b0, prev_len_q};
	assign req_end  = {1'b0, addr_q} + {1'b0, ulen_q};
	assign jp = (pos_q != '0) && (prev_end == {1'b0, addr_q});
	assign jn = (pos_q < free_count_q) && (req_end == {1'b0, next_start_q});

	logic [IW-1:0] scan_lim;
	always_comb begin
		case (cmd.op)
			bfa_pkg::OP_SCAN_USED: scan_lim = IW'(used_count_q);
			default:               scan_lim = IW'(free_count_q);
		endcase
	end

	// Upper bound of a downward shift walk.
	function automatic logic [IW-1:0] scan_lim_shift(input bfa_pkg::dp_op_t op);
		logic [IW-1:0] r;
		r = (op == bfa_pkg::OP_SHIFT_FREE_DOWN) ? IW'(free_count_q)
			: IW'(used_count_q);
		return r;
	endfunction

	// Read address: scans and shifts both read at the issue index.
	always_comb begin
		fraddr = idx_q[FA-1:0];
		uraddr = idx_q[UA-1:0];
	end

	// Table writes.
	always_comb begin
		fwe = 1'b0; fwaddr = '0; fwdata = '0;
		uwe = 1'b0; uwaddr = '0; uwdata = '0;
		case (cmd.op)
			bfa_pkg::OP_SHIFT_FREE_DOWN: begin
				// Entry ridx moves to ridx-1.
				if (rvalid_q && !cmd.first) begin
					fwe = 1'b1;
					fwaddr = FA'(ridx_q - 1'b1);
					fwdata = {f_start_v, f_len_v};
				end
			end
			bfa_pkg::OP_SHIFT_FREE_UP: begin
				// Entry ridx moves to ridx+1.
				if (rvalid_q && !cmd.first) begin
					fwe = 1'b1;
					fwaddr = FA'(ridx_q + 1'b1);
					fwdata = {f_start_v, f_len_v};
				end
			end
			bfa_pkg::OP_SHIFT_USED_DOWN: begin
				if (rvalid_q && !cmd.first) begin
					uwe = 1'b1;
					uwaddr = UA'(ridx_q - 1'b1);
					uwdata = urdata;
				end
			end
			bfa_pkg::OP_COMMIT: begin
				if (cmd_q == bfa_pkg::CMD_ALLOC) begin
					uwe = 1'b1;
					uwaddr = UA'(used_count_q);
					uwdata = {best_start_q, size_q};
					if (best_len_q != size_q) begin
						fwe = 1'b1;
						fwaddr = FA'(best_q);
						fwdata = {LW'(best_start_q + size_q), LW'(best_len_q - size_q)};
					end
				end else if (jp) begin
					fwe = 1'b1;
					fwaddr = FA'(pos_q - 1'b1);
					fwdata = {prev_start_q,
						jn ? LW'(prev_len_q + ulen_q + next_len_q) : LW'(prev_len_q + ulen_q)};
				end else if (jn) begin
					fwe = 1'b1;
					fwaddr = FA'(pos_q);
					fwdata = {addr_q, LW'(ulen_q + next_len_q)};
				end else begin
					fwe = 1'b1;
					fwaddr = FA'(pos_q);
					fwdata = {addr_q, ulen_q};
				end
			end
			default: ;
		endcase
	end

	// Sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q          <= 1'b0;
			size_q         <= '0;
			addr_q         <= '0;
			free_count_q   <= FC'(1);
			used_count_q   <= '0;
			entry0_valid_q <= 1'b0;
			idx_q          <= '0;
			rvalid_q       <= 1'b0;
			ridx_q         <= '0;
			found_q        <= 1'b0;
			best_q         <= '0;
			best_len_q     <= '0;
			best_start_q   <= '0;
			uhit_q         <= '0;
			ulen_q         <= '0;
			pos_q          <= '0;
			prev_start_q   <= '0;
			prev_len_q     <= '0;
			next_start_q   <= '0;
			next_len_q     <= '0;
			pos_done_q     <= 1'b0;
		end else begin
			if (fwe && fwaddr == '0) begin
				entry0_valid_q <= 1'b1;
			end
			case (cmd.op)
				bfa_pkg::OP_LATCH: begin
					cmd_q  <= in_command;
					size_q <= LW'(in_size);
					addr_q <= LW'(in_addr);
				end
				bfa_pkg::OP_SCAN_FREE, bfa_pkg::OP_SCAN_USED, bfa_pkg::OP_FREE_POS: begin
					if (cmd.first) begin
						idx_q      <= '0;
						rvalid_q   <= 1'b0;
						found_q    <= 1'b0;
						pos_done_q <= 1'b0;
						pos_q      <= '0;
					end else begin
						rvalid_q <= idx_q < scan_lim;
						ridx_q   <= idx_q;
						if (idx_q < scan_lim) begin
							idx_q <= idx_q + 1'b1;
						end
						if (rvalid_q) begin
							if (cmd.op == bfa_pkg::OP_SCAN_FREE) begin
								if (f_len_v >= size_q && (!found_q || f_len_v < best_len_q)) begin
									found_q      <= 1'b1;
									best_q       <= FC'(ridx_q);
									best_len_q   <= f_len_v;
									best_start_q <= f_start_v;
								end
							end else if (cmd.op == bfa_pkg::OP_SCAN_USED) begin
								if (!found_q && u_start == addr_q) begin
									found_q <= 1'b1;
									uhit_q  <= UC'(ridx_q);
									ulen_q  <= u_len;
								end
							end else if (!pos_done_q) begin
								if (f_start_v <= addr_q) begin
									pos_q        <= FC'(ridx_q + 1'b1);
									prev_start_q <= f_start_v;
									prev_len_q   <= f_len_v;
								end else begin
									pos_done_q   <= 1'b1;
									next_start_q <= f_start_v;
									next_len_q   <= f_len_v;
								end
							end
						end
					end
				end
				bfa_pkg::OP_SHIFT_FREE_DOWN, bfa_pkg::OP_SHIFT_USED_DOWN: begin
					// Start one above the removed entry, walk up to the count.
					if (cmd.first) begin
						rvalid_q <= 1'b0;
						if (cmd.op == bfa_pkg::OP_SHIFT_FREE_DOWN) begin
							idx_q <= ((cmd_q == bfa_pkg::CMD_ALLOC) ? IW'(best_q) : IW'(pos_q))
								+ 1'b1;
						end else begin
							idx_q <= IW'(uhit_q) + 1'b1;
						end
					end else begin
						rvalid_q <= idx_q < scan_lim_shift(cmd.op);
						ridx_q   <= idx_q;
						if (idx_q < scan_lim_shift(cmd.op)) begin
							idx_q <= idx_q + 1'b1;
						end
						if (stat.shift_done) begin
							if (cmd.op == bfa_pkg::OP_SHIFT_FREE_DOWN) begin
								free_count_q <= free_count_q - 1'b1;
							end else begin
								used_count_q <= used_count_q - 1'b1;
							end
						end
					end
				end
				bfa_pkg::OP_SHIFT_FREE_UP: begin
					// Walk from the top entry down to the insert position.
					if (cmd.first) begin
						rvalid_q <= 1'b0;
						idx_q    <= IW'(free_count_q) - 1'b1;
					end else begin
						rvalid_q <= (idx_q >= IW'(pos_q)) && !idx_q[IW-1];
						ridx_q   <= idx_q;
						if ((idx_q >= IW'(pos_q)) && !idx_q[IW-1]) begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				bfa_pkg::OP_COMMIT: begin
					if (cmd_q == bfa_pkg::CMD_ALLOC) begin
						used_count_q <= used_count_q + 1'b1;
					end else if (!jp && !jn) begin
						free_count_q <= free_count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Status to the controller.
	always_comb begin
		stat.scan_done  = !rvalid_q && (idx_q >= scan_lim);
		stat.shift_done = (cmd.op == bfa_pkg::OP_SHIFT_FREE_UP)
			? (!rvalid_q && (idx_q[IW-1] || idx_q < IW'(pos_q)))
			: (!rvalid_q && idx_q >= scan_lim_shift(cmd.op));
		stat.found      = found_q;
		stat.exact_fit  = best_len_q == size_q;
		stat.join_prev  = jp;
		stat.join_next  = jn;
		stat.free_full  = free_count_q >= FC'(FREE_ENTRIES);
		stat.used_full  = used_count_q >= UC'(USED_ENTRIES);
	end

	assign res_addr    = best_start_q[10:0];
	assign req_is_free = cmd_q;
	assign size_zero   = size_q == '0;
endmodule

@@ src/bfa_ctrl.sv @@
// Controller state machine sequencing scans, table shifts and the result of each request.
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	output logic              in_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        res_status,
	output logic              res_grant,
	output bfa_pkg::dp_cmd_t  cmd,
	input  bfa_pkg::dp_stat_t stat,
	input  logic              req_is_free,
	input  logic              size_zero
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN_F, S_SCAN_U, S_POS, S_CHECK,
		S_COMMIT, S_SHIFT_FD, S_SHIFT_FU, S_SHIFT_UD, S_DONE
	} state_t;

	state_t     state_q;
	logic       first_q;
	logic       res_valid_q;
	logic [1:0] res_status_q;
	logic       res_grant_q;

	assign in_ready   = state_q == S_IDLE && !res_valid_q;
	assign res_valid  = res_valid_q;
	assign res_status = res_status_q;
	assign res_grant  = res_grant_q;

	// Command to the datapath for the present state.
	always_comb begin
		cmd.first = first_q;
		case (state_q)
			S_IDLE:     cmd.op = in_fire ? bfa_pkg::OP_LATCH : bfa_pkg::OP_NONE;
			S_SCAN_F:   cmd.op = bfa_pkg::OP_SCAN_FREE;
			S_SCAN_U:   cmd.op = bfa_pkg::OP_SCAN_USED;
			S_POS:      cmd.op = bfa_pkg::OP_FREE_POS;
			S_SHIFT_FD: cmd.op = bfa_pkg::OP_SHIFT_FREE_DOWN;
			S_SHIFT_FU: cmd.op = bfa_pkg::OP_SHIFT_FREE_UP;
			S_SHIFT_UD: cmd.op = bfa_pkg::OP_SHIFT_USED_DOWN;
			S_COMMIT:   cmd.op = bfa_pkg::OP_COMMIT;
			default:    cmd.op = bfa_pkg::OP_NONE;
		endcase
	end

	// State and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_q      <= 1'b0;
			res_valid_q  <= 1'b0;
			res_status_q <= bfa_pkg::ST_OK;
			res_grant_q  <= 1'b0;
		end else begin
			first_q <= 1'b0;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					first_q <= 1'b1;
					if (req_is_free) begin
						state_q <= S_SCAN_U;
					end else if (size_zero) begin
						res_status_q <= bfa_pkg::ST_NO_FIT;
						res_grant_q  <= 1'b0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SCAN_F;
					end
				end
				S_SCAN_F: begin
					if (!first_q && stat.scan_done) begin
						res_grant_q <= 1'b0;
						if (!stat.found) begin
							res_status_q <= bfa_pkg::ST_NO_FIT;
							state_q      <= S_DONE;
						end else if (stat.used_full) begin
							res_status_q <= bfa_pkg::ST_TABLE_FULL;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_SCAN_U: begin
					if (!first_q && stat.scan_done) begin
						res_grant_q <= 1'b0;
						first_q     <= 1'b1;
						if (!stat.found) begin
							res_status_q <= bfa_pkg::ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_POS;
						end
					end
				end
				S_POS: begin
					if (!first_q && stat.scan_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					first_q <= 1'b1;
					if (!stat.join_prev && !stat.join_next && stat.free_full) begin
						res_status_q <= bfa_pkg::ST_TABLE_FULL;
						state_q      <= S_DONE;
					end else if (stat.join_prev && stat.join_next) begin
						state_q <= S_COMMIT;
					end else if (!stat.join_prev && !stat.join_next) begin
						state_q <= S_SHIFT_FU;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_SHIFT_FU: begin
					if (!first_q && stat.shift_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					first_q      <= 1'b1;
					res_status_q <= bfa_pkg::ST_OK;
					if (!req_is_free) begin
						// An exact fit uses up the segment, which leaves the free table.
						res_grant_q <= 1'b1;
						if (stat.exact_fit) begin
							state_q <= S_SHIFT_FD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (stat.join_prev && stat.join_next) begin
						state_q <= S_SHIFT_FD;
					end else begin
						state_q <= S_SHIFT_UD;
					end
				end
				S_SHIFT_FD: begin
					if (!first_q && stat.shift_done) begin
						first_q <= 1'b1;
						state_q <= req_is_free ? S_SHIFT_UD : S_DONE;
					end
				end
				S_SHIFT_UD: begin
					if (!first_q && stat.shift_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ src/best_fit_allocator_coalescing_top.sv @@
// Top level of the best-fit allocator with coalescing free table.
//  channel | direction | tdata fields (low bit first)          | tuser
//  s_axis  | in        | command, request_size, block_address    | -
//  m_axis  | out       | granted_address, status                 | -
// A request passes an accept state and a decode state, one walk of the free table
// (allocate) or of the used table and then the free table (free), then table shifts
// of up to one walk each.
// Reset sets the counts to one free segment and no used blocks; the tables need no clearing pass.
// A result waits in its output register; the next request is taken once it has gone.
`include "assert_macros.svh"
module best_fit_allocator_coalescing_top #(
	parameter int FREE_ENTRIES = 64,
	parameter int USED_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // command[0], request_size[12:1], block_address[23:13]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // granted_address[10:0], status[12:11], zero fill
);
	bfa_pkg::dp_cmd_t  cmd;
	bfa_pkg::dp_stat_t stat;
	logic        in_fire, res_grant, req_is_free, size_zero;
	logic [1:0]  res_status;
	logic [10:0] res_addr;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	bfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_ready(s_axis_tready),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_status(res_status),
		.res_grant(res_grant), .cmd(cmd), .stat(stat),
		.req_is_free(req_is_free), .size_zero(size_zero));

	bfa_datapath #(
		.FREE_ENTRIES(FREE_ENTRIES), .USED_ENTRIES(USED_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_command(s_axis_tdata[0]), .in_size(s_axis_tdata[12:1]),
		.in_addr(s_axis_tdata[23:13]), .res_addr(res_addr),
		.req_is_free(req_is_free), .size_zero(size_zero));

	// Result transfer: address only on a successful grant.
	assign m_axis_tdata = {3'b000, res_status,
		(res_grant && res_status == bfa_pkg::ST_OK) ? res_addr : 11'd0};

	// No request is taken while a result waits.
	`ASSERT_IMPLIES(a_no_take_busy, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	// A granted address goes out only with ok status.
	`ASSERT_IMPLIES(a_addr_ok, clk, arst_n, m_axis_tvalid && m_axis_tdata[10:0] != 11'd0,
		m_axis_tdata[12:11] == bfa_pkg::ST_OK)
	// An accepted request closes the input side on the next cycle.
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_fire, !s_axis_tready)
endmodule

@@ tb/best_fit_allocator_coalescing_top_test.sv @@
// Self-checking testbench for the best-fit allocator with a coalescing free table.
`timescale 1ns / 100ps
module best_fit_allocator_coalescing_top_test;
	localparam int REGION = 2048;
	localparam int FREE_DEPTH = 64;
	localparam int USED_DEPTH = 64;

	typedef struct packed {
		logic [10:0] addr;
		logic [1:0]  status;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // command[0], request_size[12:1], block_address[23:13]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // granted_address[10:0], status[12:11], zero fill

	// Shadow copy of the allocator tables.
	int     seg_start [FREE_DEPTH];
	int     seg_len   [FREE_DEPTH];
	int     seg_count;
	int     blk_start [USED_DEPTH];
	int     blk_len   [USED_DEPTH];
	int     blk_count;
	grant_t pending_grants[$];
	int     failures;
	bit     steady;          // when set, neither side idles

	best_fit_allocator_coalescing_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Removes one segment from the free table, closing the gap.
	function automatic void drop_segment(int pos);
		for (int i = pos; i + 1 < seg_count; i++) begin
			seg_start[i] = seg_start[i + 1];
			seg_len[i] = seg_len[i + 1];
		end
		seg_count--;
	endfunction

	// Best-fit allocation on the shadow tables.
	function automatic grant_t allocate_block(int size);
		grant_t g;
		int best;
		int best_len;
		bit found;
		g = '0;
		best = 0;
		best_len = 0;
		found = 0;
		if (size == 0) begin
			g.status = bfa_pkg::ST_NO_FIT;
			return g;
		end
		for (int i = 0; i < seg_count; i++) begin
			if (seg_len[i] >= size && (!found || seg_len[i] < best_len)) begin
				found = 1;
				best = i;
				best_len = seg_len[i];
			end
		end
		if (!found) begin
			g.status = bfa_pkg::ST_NO_FIT;
			return g;
		end
		if (blk_count >= USED_DEPTH) begin
			g.status = bfa_pkg::ST_TABLE_FULL;
			return g;
		end
		g.addr = seg_start[best][10:0];
		g.status = bfa_pkg::ST_OK;
		blk_start[blk_count] = seg_start[best];
		blk_len[blk_count] = size;
		blk_count++;
		if (best_len == size)
			drop_segment(best);
		else begin
			seg_start[best] += size;
			seg_len[best] -= size;
		end
		return g;
	endfunction

	// Returns a block to the free table and merges it with touching neighbours.
	function automatic grant_t release_block(int addr);
		grant_t g;
		int u;
		int p;
		int len;
		bit hit;
		bit join_prev;
		bit join_next;
		g = '0;
		u = 0;
		hit = 0;
		for (int i = 0; i < blk_count; i++) begin
			if (!hit && blk_start[i] == addr) begin
				hit = 1;
				u = i;
			end
		end
		if (!hit) begin
			g.status = bfa_pkg::ST_NOT_FOUND;
			return g;
		end
		len = blk_len[u];
		p = 0;
		while (p < seg_count && seg_start[p] <= addr)
			p++;
		join_prev = p > 0 && seg_start[p - 1] + seg_len[p - 1] == addr;
		join_next = p < seg_count && addr + len == seg_start[p];
		if (!join_prev && !join_next && seg_count >= FREE_DEPTH) begin
			g.status = bfa_pkg::ST_TABLE_FULL;
			return g;
		end
		if (join_prev && join_next) begin
			seg_len[p - 1] += len + seg_len[p];
			drop_segment(p);
		end else if (join_prev) begin
			seg_len[p - 1] += len;
		end else if (join_next) begin
			seg_start[p] = addr;
			seg_len[p] += len;
		end else begin
			for (int i = seg_count; i > p; i--) begin
				seg_start[i] = seg_start[i - 1];
				seg_len[i] = seg_len[i - 1];
			end
			seg_start[p] = addr;
			seg_len[p] = len;
			seg_count++;
		end
		for (int i = u; i + 1 < blk_count; i++) begin
			blk_start[i] = blk_start[i + 1];
			blk_len[i] = blk_len[i + 1];
		end
		blk_count--;
		g.status = bfa_pkg::ST_OK;
		return g;
	endfunction

	// Sends one request and records the grant it should produce once accepted.
	task automatic send_request(logic cmd, logic [11:0] size, logic [10:0] addr);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {addr, size, cmd};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (cmd == bfa_pkg::CMD_ALLOC)
			pending_grants.push_back(allocate_block(size));
		else
			pending_grants.push_back(release_block(addr));
		@(negedge clk);
	endtask

	task automatic alloc_req(int size);
		send_request(bfa_pkg::CMD_ALLOC, size[11:0], 11'($urandom_range(0, 2047)));
	endtask

	task automatic free_req(int addr);
		send_request(bfa_pkg::CMD_FREE, 12'($urandom_range(0, 4095)), addr[10:0]);
	endtask

	// Field extremes, zero size, oversized requests and unknown addresses.
	task automatic test_edge_requests();
		alloc_req(0);
		alloc_req(4095);
		alloc_req(2049);
		free_req(0);
		free_req(2047);
		alloc_req(2048);
		alloc_req(1);
		free_req(0);
		alloc_req(1);
		alloc_req(2047);
		free_req(2047);
		free_req(1);
		free_req(0);
		free_req(0);
	endtask

	// Splits, ties on size, and releases that insert, merge with the next segment or merge with both.
	task automatic test_split_and_merge();
		alloc_req(100);
		alloc_req(200);
		alloc_req(100);
		alloc_req(300);
		free_req(0);
		free_req(300);
		alloc_req(100);
		free_req(100);
		free_req(0);
		free_req(400);
		free_req(300);
	endtask

	// Fills the used table and empties it, then fills the whole region and empties it again.
	task automatic test_used_table_full();
		for (int i = 0; i < USED_DEPTH; i++)
			alloc_req(31);
		alloc_req(1);
		alloc_req(65);
		for (int i = 0; i < USED_DEPTH; i += 2)
			free_req(i * 31);
		for (int i = USED_DEPTH - 1; i > 0; i -= 2)
			free_req(i * 31);
		for (int i = 0; i < USED_DEPTH / 2; i++)
			alloc_req(64);
		alloc_req(1);
		for (int i = 0; i < USED_DEPTH / 2; i++)
			free_req(i * 64);
	endtask

	// Random mix, mostly well-formed: frees aim at live blocks, sizes stay small.
	task automatic test_random_traffic(int items);
		int r;
		int size;
		for (int n = 0; n < items; n++) begin
			steady = (n / 300) % 3 == 2;
			r = $urandom_range(0, 99);
			if (blk_count > 0 && r < 45)
				free_req(blk_start[$urandom_range(0, blk_count - 1)]);
			else if (r < 50)
				free_req($urandom_range(0, 2047));
			else begin
				r = $urandom_range(0, 99);
				if (r < 78)
					size = $urandom_range(1, 64);
				else if (r < 94)
					size = $urandom_range(65, 512);
				else if (r < 99)
					size = $urandom_range(0, 4095);
				else
					size = 0;
				alloc_req(size);
			end
		end
		steady = 0;
	endtask

	// Receiver back-pressure, changed at the falling edge.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			gap = idle_length();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// Each result transfer is checked against the oldest expected grant.
	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result tdata=%h", $time, m_axis_tdata);
				failures++;
			end else begin
				exp_g = pending_grants.pop_front();
				if (m_axis_tdata[10:0] !== exp_g.addr) begin
					$display("%0t: granted_address expected %0d actual %0d", $time,
						exp_g.addr, m_axis_tdata[10:0]);
					failures++;
				end
				if (m_axis_tdata[12:11] !== exp_g.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_g.status, m_axis_tdata[12:11]);
					failures++;
				end
			end
		end
	end

	// Run limit.
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		failures = 0;
		steady = 0;
		seg_start[0] = 0;
		seg_len[0] = REGION;
		seg_count = 1;
		blk_count = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_edge_requests();
		test_split_and_merge();
		test_used_table_full();
		test_random_traffic(1680);
		s_axis_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (failures == 0 && pending_grants.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
